[rtl/core/sfd_pkg.sv]
// sfd_pkg: event codes, slave kinds, register indexes and command id decode
// shared by the status frame deframer; no dependencies
package sfd_pkg;

  typedef logic [2:0] event_t;
  localparam event_t EV_HEADER  = 3'd0;
  localparam event_t EV_PAYLOAD = 3'd1;
  localparam event_t EV_GOOD    = 3'd2;
  localparam event_t EV_BAD     = 3'd3;
  localparam event_t EV_TRUNC   = 3'd4;
  localparam event_t EV_IGNORED = 3'd5;

  typedef logic [1:0] kind_t;
  localparam kind_t KIND_RT   = 2'd0;
  localparam kind_t KIND_IF   = 2'd1;
  localparam kind_t KIND_ATT  = 2'd2;
  localparam kind_t KIND_NONE = 2'd3;

  typedef logic [2:0] reg_idx_t;
  localparam reg_idx_t REG_RF_FORWARD = 3'd0;
  localparam reg_idx_t REG_RF_AFT     = 3'd1;
  localparam reg_idx_t REG_IF_FORWARD = 3'd2;
  localparam reg_idx_t REG_IF_AFT     = 3'd3;
  localparam reg_idx_t REG_ATTENUATOR = 3'd4;

  // command ids
  localparam logic [7:0] CMD_STATUS    = 8'h01;
  localparam logic [7:0] CMD_RESET     = 8'h02;
  localparam logic [7:0] CMD_SELFTEST  = 8'h05;
  localparam logic [7:0] CMD_RT_EXTRA  = 8'h06;
  localparam logic [7:0] CMD_VERSION   = 8'h10;
  localparam logic [7:0] CMD_ATT_FIRST = 8'h11;
  localparam logic [7:0] CMD_ATT_LAST  = 8'h15;

  function automatic logic cmd_known(input kind_t kind, input logic [7:0] c);
    logic common;
    common = (c == CMD_STATUS) || (c == CMD_RESET) || (c == CMD_SELFTEST) ||
             (c == CMD_VERSION);
    case (kind)
      KIND_RT:  cmd_known = common || (c == CMD_RT_EXTRA);
      KIND_IF:  cmd_known = common;
      KIND_ATT: cmd_known = common || ((c >= CMD_ATT_FIRST) && (c <= CMD_ATT_LAST));
      default:  cmd_known = 1'b0;
    endcase
  endfunction

endpackage

[rtl/core/status_frame_deframer.sv]
// status_frame_deframer: top level, byte-wise parser of error-status frames
// depends on sfd_pkg for event codes, slave kinds and command id decode
//
// Takes one status byte per transaction and returns exactly one result
// transaction for it. A frame is address, length, command id, length status
// bytes and a checksum that must equal the 8-bit wrapping sum of all earlier
// bytes. Each byte is decoded in the cycle it is accepted and its result is
// held in the output register, and a new byte can be taken every cycle; the
// only thing that slows the input is the output register: while a result
// waits and out_ready is low, in_ready is low. The address byte of each
// frame sets that slave's bit in a sticky dead-slave map (SLAVE_SLOTS bits,
// addresses beyond it are ignored); out_dead_map shows the low eight bits.
// Slave addresses are set through the cfg_ write port, which must only be
// written while the block is idle.
module status_frame_deframer #(
  parameter int SLAVE_SLOTS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  // configuration
  input  logic              cfg_we,
  input  sfd_pkg::reg_idx_t cfg_index,
  input  logic [7:0]        cfg_wdata,
  // input transactions
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_fifo_empty,
  input  logic              in_frame_start,
  // result transactions
  output logic              out_valid,
  input  logic              out_ready,
  output sfd_pkg::event_t   out_event_res,
  output logic [7:0]        out_payload_byte,
  output logic [7:0]        out_payload_index,
  output logic [7:0]        out_slave_addr,
  output logic [7:0]        out_command_id,
  output sfd_pkg::kind_t    out_slave_kind,
  output logic              out_command_known,
  output logic [7:0]        out_computed_sum,
  output logic [7:0]        out_dead_map
);
  import sfd_pkg::*;

  // map padded to at least eight bits for the output view
  localparam int MapW = (SLAVE_SLOTS > 8) ? SLAVE_SLOTS : 8;

  typedef enum logic [2:0] {
    PH_IDLE, PH_LEN, PH_CMD, PH_DATA, PH_SUM
  } phase_t;

  // frame state
  phase_t                 phase_r, phase_nxt;
  logic [7:0]             sum_r, sum_nxt;
  logic [7:0]             addr_r, addr_nxt;
  logic [7:0]             len_r, len_nxt;
  logic [7:0]             seen_r, seen_nxt;
  logic [7:0]             cmd_r, cmd_nxt;
  logic [SLAVE_SLOTS-1:0] dead_r, dead_nxt;
  logic [MapW-1:0]        dead_ext;

  // slave address registers
  logic [7:0] rf_fwd_r, rf_aft_r, if_fwd_r, if_aft_r, att_r;

  // output register
  logic       out_valid_r;
  event_t     ev_r, ev_nxt;
  logic [7:0] pbyte_r, pbyte_nxt;
  logic [7:0] pidx_r, pidx_nxt;
  logic [7:0] oaddr_r, ocmd_r, osum_r, odead_r;
  kind_t      kind_r, kind_nxt;
  logic       known_r, known_nxt;

  logic  in_acc;
  kind_t frame_kind;

  // output register empties when taken, so a byte goes in whenever a slot is free
  assign in_ready = !out_valid_r || out_ready;
  assign in_acc   = in_valid && in_ready;

  // slave kind of the current frame, first match in register order wins
  always_comb begin
    if ((addr_r == rf_fwd_r) || (addr_r == rf_aft_r)) begin
      frame_kind = KIND_RT;
    end else if ((addr_r == if_fwd_r) || (addr_r == if_aft_r)) begin
      frame_kind = KIND_IF;
    end else if (addr_r == att_r) begin
      frame_kind = KIND_ATT;
    end else begin
      frame_kind = KIND_NONE;
    end
  end

  // per-byte decode
  always_comb begin
    phase_nxt = phase_r;
    sum_nxt   = sum_r;
    addr_nxt  = addr_r;
    len_nxt   = len_r;
    seen_nxt  = seen_r;
    cmd_nxt   = cmd_r;
    dead_nxt  = dead_r;
    ev_nxt    = EV_IGNORED;
    pbyte_nxt = 8'd0;
    pidx_nxt  = 8'd0;
    kind_nxt  = KIND_NONE;
    known_nxt = 1'b0;

    if (in_fifo_empty) begin
      // empty fifo abandons a frame in progress, ignored while idle
      if (phase_r != PH_IDLE) begin
        ev_nxt    = EV_TRUNC;
        phase_nxt = PH_IDLE;
      end
    end else if (in_frame_start) begin
      // new frame, drops any frame in progress without a report
      addr_nxt  = in_byte;
      sum_nxt   = in_byte;
      len_nxt   = 8'd0;
      seen_nxt  = 8'd0;
      cmd_nxt   = 8'd0;
      for (int i = 0; i < SLAVE_SLOTS; i++) begin
        if (in_byte == 8'(i)) begin
          dead_nxt[i] = 1'b1;
        end
      end
      phase_nxt = PH_LEN;
      ev_nxt    = EV_HEADER;
    end else begin
      case (phase_r)
        PH_IDLE: begin
          ev_nxt = EV_IGNORED;
        end
        PH_LEN: begin
          len_nxt   = in_byte;
          sum_nxt   = sum_r + in_byte;
          phase_nxt = PH_CMD;
          ev_nxt    = EV_HEADER;
        end
        PH_CMD: begin
          cmd_nxt   = in_byte;
          sum_nxt   = sum_r + in_byte;
          // zero length goes straight to the checksum
          phase_nxt = (len_r == 8'd0) ? PH_SUM : PH_DATA;
          ev_nxt    = EV_HEADER;
        end
        PH_DATA: begin
          pbyte_nxt = in_byte;
          pidx_nxt  = seen_r;
          sum_nxt   = sum_r + in_byte;
          seen_nxt  = seen_r + 8'd1;
          if (seen_nxt >= len_r) begin
            phase_nxt = PH_SUM;
          end
          ev_nxt    = EV_PAYLOAD;
        end
        PH_SUM: begin
          ev_nxt    = (in_byte == sum_r) ? EV_GOOD : EV_BAD;
          kind_nxt  = frame_kind;
          known_nxt = cmd_known(frame_kind, cmd_r);
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
          ev_nxt    = EV_IGNORED;
        end
      endcase
    end
  end

  assign dead_ext = MapW'(dead_nxt);

  // state, configuration and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      sum_r       <= 8'd0;
      addr_r      <= 8'd0;
      len_r       <= 8'd0;
      seen_r      <= 8'd0;
      cmd_r       <= 8'd0;
      dead_r      <= '0;
      rf_fwd_r    <= 8'd0;
      rf_aft_r    <= 8'd1;
      if_fwd_r    <= 8'd2;
      if_aft_r    <= 8'd3;
      att_r       <= 8'd4;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_RF_FORWARD: rf_fwd_r <= cfg_wdata;
          REG_RF_AFT:     rf_aft_r <= cfg_wdata;
          REG_IF_FORWARD: if_fwd_r <= cfg_wdata;
          REG_IF_AFT:     if_aft_r <= cfg_wdata;
          REG_ATTENUATOR: att_r    <= cfg_wdata;
          default: ;
        endcase
      end
      if (in_acc) begin
        phase_r     <= phase_nxt;
        sum_r       <= sum_nxt;
        addr_r      <= addr_nxt;
        len_r       <= len_nxt;
        seen_r      <= seen_nxt;
        cmd_r       <= cmd_nxt;
        dead_r      <= dead_nxt;
        out_valid_r <= 1'b1;
        ev_r        <= ev_nxt;
        pbyte_r     <= pbyte_nxt;
        pidx_r      <= pidx_nxt;
        oaddr_r     <= addr_nxt;
        ocmd_r      <= cmd_nxt;
        kind_r      <= kind_nxt;
        known_r     <= known_nxt;
        osum_r      <= sum_nxt;
        odead_r     <= dead_ext[7:0];
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_event_res     = ev_r;
  assign out_payload_byte  = pbyte_r;
  assign out_payload_index = pidx_r;
  assign out_slave_addr    = oaddr_r;
  assign out_command_id    = ocmd_r;
  assign out_slave_kind    = kind_r;
  assign out_command_known = known_r;
  assign out_computed_sum  = osum_r;
  assign out_dead_map      = odead_r;

`ifndef ASSERT_OFF
  // a free output slot always takes a byte
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_ready)
    else $error("in_ready low with empty output register");

  // kind and command decode only reported at the checksum
  a_kind_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (ev_r != EV_GOOD) && (ev_r != EV_BAD)
      |-> (kind_r == KIND_NONE) && !known_r)
    else $error("slave kind reported outside frame end");

  // status byte field is zero unless a payload event
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (ev_r != EV_PAYLOAD) |-> (pbyte_r == 8'd0) && (pidx_r == 8'd0))
    else $error("payload fields set on non-payload event");

  // dead map is sticky
  a_dead_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((dead_r & $past(dead_r)) == $past(dead_r)))
    else $error("dead-slave bit cleared");

  // a pending result is not overwritten by a stalled output
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |=> out_valid_r && $stable(ev_r) && $stable(osum_r))
    else $error("stalled result changed");
`endif

endmodule
